/* hw/rtl/sne_pkg.sv */
// Shared types, constants and the character lookup for the shifted nibble text encoder.
// No dependencies.
`timescale 1ns / 1ps

package sne_pkg;

	localparam logic [3:0] SHIFT_BASE = 4'd12;
	localparam logic [3:0] PAD_CODE   = 4'd15;
	localparam logic [7:0] END_CHAR   = 8'h00;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       found;
		logic       upper;
		logic [1:0] row;
		logic [3:0] col;
	} sne_hit_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] data0;
		logic [7:0] data1;
	} sne_enq_t;

	// Position of a character; '*' resolves to lower row 0 column 2.
	function automatic sne_hit_t sne_lookup(input logic [7:0] ch);
		sne_hit_t h;
		h = '0;
		h.found = 1'b1;
		case (ch) inside
			// upper, row 0
			[8'h30:8'h39]: begin h.upper = 1'b1; h.row = 2'd0; h.col = 4'(ch - 8'h30); end
			8'h2B: begin h.upper = 1'b1; h.row = 2'd0; h.col = 4'd10; end
			8'h2D: begin h.upper = 1'b1; h.row = 2'd0; h.col = 4'd11; end
			// upper, row 1
			8'h27: begin h.upper = 1'b1; h.row = 2'd1; h.col = 4'd0; end
			[8'h41:8'h49]: begin h.upper = 1'b1; h.row = 2'd1; h.col = 4'(ch - 8'h40); end
			8'h5B: begin h.upper = 1'b1; h.row = 2'd1; h.col = 4'd10; end
			8'h5D: begin h.upper = 1'b1; h.row = 2'd1; h.col = 4'd11; end
			// upper, row 2
			8'h22: begin h.upper = 1'b1; h.row = 2'd2; h.col = 4'd0; end
			[8'h4A:8'h52]: begin h.upper = 1'b1; h.row = 2'd2; h.col = 4'(ch - 8'h49); end
			8'h7B: begin h.upper = 1'b1; h.row = 2'd2; h.col = 4'd10; end
			8'h7D: begin h.upper = 1'b1; h.row = 2'd2; h.col = 4'd11; end
			// upper, row 3
			8'h20: begin h.upper = 1'b1; h.row = 2'd3; h.col = 4'd1; end
			[8'h53:8'h5A]: begin h.upper = 1'b1; h.row = 2'd3; h.col = 4'(ch - 8'h51); end
			8'h5F: begin h.upper = 1'b1; h.row = 2'd3; h.col = 4'd10; end
			8'h2C: begin h.upper = 1'b1; h.row = 2'd3; h.col = 4'd11; end
			// lower, row 0
			8'h7C: begin h.row = 2'd0; h.col = 4'd0; end
			8'h21: begin h.row = 2'd0; h.col = 4'd1; end
			8'h2A: begin h.row = 2'd0; h.col = 4'd2; end
			8'h23: begin h.row = 2'd0; h.col = 4'd3; end
			8'h25: begin h.row = 2'd0; h.col = 4'd5; end
			8'h26: begin h.row = 2'd0; h.col = 4'd6; end
			8'h5E: begin h.row = 2'd0; h.col = 4'd7; end
			8'h3F: begin h.row = 2'd0; h.col = 4'd8; end
			8'h2E: begin h.row = 2'd0; h.col = 4'd9; end
			8'h3B: begin h.row = 2'd0; h.col = 4'd10; end
			8'h3D: begin h.row = 2'd0; h.col = 4'd11; end
			// lower, row 1
			8'h40: begin h.row = 2'd1; h.col = 4'd0; end
			[8'h61:8'h69]: begin h.row = 2'd1; h.col = 4'(ch - 8'h60); end
			8'h28: begin h.row = 2'd1; h.col = 4'd10; end
			8'h29: begin h.row = 2'd1; h.col = 4'd11; end
			// lower, row 2
			8'h5C: begin h.row = 2'd2; h.col = 4'd0; end
			[8'h6A:8'h72]: begin h.row = 2'd2; h.col = 4'(ch - 8'h69); end
			8'h3C: begin h.row = 2'd2; h.col = 4'd10; end
			8'h3E: begin h.row = 2'd2; h.col = 4'd11; end
			// lower, row 3
			8'h60: begin h.row = 2'd3; h.col = 4'd0; end
			8'h7E: begin h.row = 2'd3; h.col = 4'd1; end
			[8'h73:8'h7A]: begin h.row = 2'd3; h.col = 4'(ch - 8'h71); end
			8'h2F: begin h.row = 2'd3; h.col = 4'd10; end
			8'h3A: begin h.row = 2'd3; h.col = 4'd11; end
			default: h.found = 1'b0;
		endcase
		return h;
	endfunction

endpackage

/* hw/rtl/sne_core.sv */
// Input register, code state and nibble packing for the shifted nibble text encoder.
// Depends on sne_pkg.
`timescale 1ns / 1ps

module sne_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       text_char,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             room,
	output sne_pkg::sne_enq_t enq
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       upper_q;
	logic [1:0] row_q;
	logic [3:0] held_q;
	logic       wait_q;

	logic       adv;
	logic       upper_d;
	logic [1:0] row_d;
	logic [3:0] held_d;
	logic       wait_d;
	logic [1:0] cnt;
	logic [3:0] nib [4];
	logic [2:0] k;
	sne_pkg::sne_hit_t hit;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= text_char;
		end
	end

	always_comb begin
		hit     = sne_pkg::sne_lookup(char_s1);
		nib     = '{default: 4'd0};
		k       = 3'd0;
		upper_d = upper_q;
		row_d   = row_q;
		held_d  = held_q;
		wait_d  = wait_q;
		cnt     = 2'd0;
		if (wait_q) begin
			nib[0] = held_q;
			k      = 3'd1;
		end
		if (hit.upper != upper_q) begin
			nib[k[1:0]] = sne_pkg::SHIFT_BASE + {2'b00, row_q};
			k           = k + 3'd1;
		end
		if (hit.row != row_q) begin
			nib[k[1:0]] = sne_pkg::SHIFT_BASE + {2'b00, hit.row};
			k           = k + 3'd1;
		end
		nib[k[1:0]] = hit.col;
		k           = k + 3'd1;

		enq.data0 = {nib[0], nib[1]};
		enq.data1 = {nib[2], nib[3]};
		if (char_s1 == sne_pkg::END_CHAR) begin
			enq.data0 = {held_q, sne_pkg::PAD_CODE};
			cnt       = {1'b0, wait_q};
			upper_d   = 1'b1;
			row_d     = 2'd0;
			held_d    = 4'd0;
			wait_d    = 1'b0;
		end else if (hit.found) begin
			cnt     = k[2:1];
			upper_d = hit.upper;
			row_d   = hit.row;
			wait_d  = k[0];
			held_d  = k[1] ? nib[2] : nib[0];
		end
		enq.cnt = adv ? cnt : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b1;
			row_q   <= 2'd0;
			held_q  <= 4'd0;
			wait_q  <= 1'b0;
		end else if (adv) begin
			upper_q <= upper_d;
			row_q   <= row_d;
			held_q  <= held_d;
			wait_q  <= wait_d;
		end
	end

endmodule

/* hw/rtl/sne_outq.sv */
// Small result queue: takes up to two bytes per cycle, gives one per ready cycle.
// Depends on sne_pkg.
`timescale 1ns / 1ps

module sne_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  sne_pkg::sne_enq_t enq,
	output logic              room,
	output logic [7:0]        packed_byte,
	output logic              run_last,
	output logic              out_valid,
	input  logic              out_ready
);

	logic [8:0]                mem_q [sne_pkg::QDEPTH];
	logic [sne_pkg::QAW-1:0]   wr_ptr_q;
	logic [sne_pkg::QAW-1:0]   rd_ptr_q;
	logic [sne_pkg::QCW-1:0]   count_q;
	logic                      pop;

	assign out_valid   = count_q != '0;
	assign pop         = out_valid && out_ready;
	assign room        = (count_q - sne_pkg::QCW'(pop)) <= sne_pkg::QCW'(sne_pkg::QDEPTH - 2);
	assign packed_byte = mem_q[rd_ptr_q][7:0];
	assign run_last    = mem_q[rd_ptr_q][8];

	always_ff @(posedge clk) begin
		if (enq.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= {enq.cnt == 2'd1, enq.data0};
		end
		if (enq.cnt == 2'd2) begin
			mem_q[wr_ptr_q + sne_pkg::QAW'(1)] <= {1'b1, enq.data1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sne_pkg::QAW'(enq.cnt);
			rd_ptr_q <= rd_ptr_q + sne_pkg::QAW'(pop);
			count_q  <= count_q + sne_pkg::QCW'(enq.cnt) - sne_pkg::QCW'(pop);
		end
	end

endmodule

/* hw/rtl/shifted_nibble_text_encoder.sv */
// Shifted nibble text encoder top level: input register and encoder, result queue.
// Depends on sne_pkg, sne_core, sne_outq.
//
// Characters enter through a one-item input register and are encoded combinationally
// into zero, one or two packed bytes, which go into a four-entry result queue that
// serves one byte per cycle while out_ready is high. A character yielding at most one
// byte is accepted every cycle while the queue has room; two bytes leave one at a time.
// A character passes the input register, then the queue. Unknown ones are dropped; a
// zero character pads and flushes a pending nibble and returns the coder to its start.
`timescale 1ns / 1ps

module shifted_nibble_text_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_char,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] packed_byte,
	output logic       run_last,
	output logic       out_valid,
	input  logic       out_ready
);

	sne_pkg::sne_enq_t enq;
	logic              room;

	sne_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_char (text_char),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.room      (room),
		.enq       (enq)
	);

	sne_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.enq         (enq),
		.room        (room),
		.packed_byte (packed_byte),
		.run_last    (run_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

/* hw/rtl/sne_checker.sv */
// Port-level checks for the shifted nibble text encoder, bound to the top level.
// Depends on shifted_nibble_text_encoder.
`timescale 1ns / 1ps

module sne_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic [7:0] packed_byte,
	input logic       run_last,
	input logic       out_valid,
	input logic       out_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_byte) && $stable(run_last))
		else $error("result changed while stalled");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("byte of an item missing after non-final byte");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result pending");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

endmodule

bind shifted_nibble_text_encoder sne_checker u_sne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.packed_byte (packed_byte),
	.run_last    (run_last),
	.out_valid   (out_valid),
	.out_ready   (out_ready)
);
